>>> design/rpa_pkg.sv
// Shared codes, field widths and beat layouts for the page allocator.
package rpa_pkg;

	localparam int PAGE_W       = 12;
	localparam int REG_W        = 13;
	localparam int REF_W        = 8;
	localparam int IN_TDATA_W   = 16;
	localparam int OUT_TDATA_W  = 24;

	localparam logic [REG_W-1:0] FIRST_PAGE_RESET = 13'd0;
	localparam logic [REG_W-1:0] LIMIT_PAGE_RESET = 13'd4096;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_ADDREF = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_WINDOW = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_LIMIT  = 2'd3
	} status_t;

	typedef enum logic {
		REG_FIRST_PAGE = 1'b0,
		REG_LIMIT_PAGE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              returned_to_pool;
		logic [REF_W-1:0]  ref_value;
		logic [PAGE_W-1:0] page_out;
		status_t           status;
	} result_t;

endpackage

>>> design/refcounted_page_allocator.sv
// Page-frame allocator: LIFO free stack plus per-page reference count table.
//
//  channel  | dir | beat contents (lowest bit first)
//  ---------+-----+----------------------------------------------------------
//  s_*      | in  | operation[1:0], page[13:2], zero pad[15:14]
//  m_*      | out | status[1:0], page_out[13:2], ref_value[21:14],
//           |     | returned_to_pool[22], zero pad[23]
//  cfg_*    | in  | index 0 first_page, index 1 limit_page, 13-bit data
//
//  Each request runs as a read step and an update step: at accept the count
//  table and the top of the free stack are read into registers; in S_EXEC both
//  memories are updated and the result register is loaded. Each memory has one write port and one registered read port.
//  After reset the count table is swept to zero, one entry a cycle, until
//  every entry is cleared; s_tready stays low during the sweep.
//  A stalled result holds the update step until the result register frees up;
//  a new request is taken while the previous result still waits.
module refcounted_page_allocator #(
	parameter int NUM_PAGES  = 4096,
	parameter int COUNT_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// operation[1:0], page[13:2], pad
	input  logic [rpa_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[1:0], page_out[13:2], ref_value[21:14], returned_to_pool[22], pad
	output logic [rpa_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [rpa_pkg::REG_W-1:0]      cfg_data
);
	import rpa_pkg::*;

	localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int DW = $clog2(NUM_PAGES + 1);
	localparam int XW = (AW > PAGE_W) ? AW : PAGE_W;
	localparam int RW = (COUNT_BITS > REF_W) ? COUNT_BITS : REF_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [DW-1:0] DEPTH_FULL = DW'(NUM_PAGES);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(NUM_PAGES - 1);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [REG_W-1:0] first_q, limit_q;

	// Request captured at accept
	op_t              op_q;
	logic [PAGE_W-1:0] page_q;

	// Control state
	logic [DW-1:0] depth_q;
	logic [AW-1:0] clr_q;
	result_t       res_q;
	logic          out_valid_q;

	// Memories
	logic [COUNT_BITS-1:0] ref_mem [NUM_PAGES];
	logic [PAGE_W-1:0]     stack_mem [NUM_PAGES];
	logic [COUNT_BITS-1:0] ref_rd_q;
	logic [PAGE_W-1:0]     stack_rd_q;

	// Combinational request decode and update
	logic                  accept;
	logic                  exec_go;
	logic [PAGE_W-1:0]     in_page;
	logic [XW-1:0]         in_page_x, page_x, got_x;
	logic [AW-1:0]         ref_ra, ref_wa, stack_wa;
	logic                  ref_we, stack_we;
	logic [COUNT_BITS-1:0] ref_wd;
	logic [DW-1:0]         depth_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic [RW-1:0]         cnt_x;
	logic                  in_win;
	result_t               res_n;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign exec_go  = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	assign in_page   = s_tdata[2 +: PAGE_W];
	assign in_page_x = XW'(in_page);
	assign page_x    = XW'(page_q);
	assign got_x     = XW'(stack_rd_q);
	assign ref_ra    = in_page_x[AW-1:0];

	// Managed window: first_page <= page < limit_page, page < NUM_PAGES
	assign in_win = (REG_W'(page_q) >= first_q) && (REG_W'(page_q) < limit_q)
		&& (32'(page_q) < 32'(NUM_PAGES));

	always_comb begin
		ref_we   = 1'b0;
		ref_wa   = page_x[AW-1:0];
		ref_wd   = '0;
		stack_we = 1'b0;
		stack_wa = depth_q[AW-1:0];
		depth_n  = depth_q;
		cnt_n    = ref_rd_q;
		cnt_x    = '0;
		res_n.status           = ST_OK;
		res_n.page_out         = page_q;
		res_n.ref_value        = '0;
		res_n.returned_to_pool = 1'b0;

		if (state_q == S_CLEAR) begin
			ref_we = 1'b1;
			ref_wa = clr_q;
		end else if (op_q == OP_ALLOC) begin
			if (depth_q == '0) begin
				res_n.status   = ST_EMPTY;
				res_n.page_out = '0;
			end else begin
				// pop: the stack top was read at accept
				depth_n         = depth_q - 1'b1;
				ref_we          = exec_go;
				ref_wa          = got_x[AW-1:0];
				ref_wd          = COUNT_BITS'(1);
				res_n.page_out  = stack_rd_q;
				res_n.ref_value = REF_W'(1);
			end
		end else if (!in_win) begin
			res_n.status = ST_WINDOW;
		end else begin
			unique case (op_q)
				OP_FREE: begin
					// a zero count counts as one, so it lands on zero
					cnt_n  = (ref_rd_q == '0) ? '0 : ref_rd_q - 1'b1;
					ref_we = exec_go;
					ref_wd = cnt_n;
					if (cnt_n != '0) begin
						cnt_x           = RW'(cnt_n);
						res_n.ref_value = cnt_x[REF_W-1:0];
					end else if (depth_q != DEPTH_FULL) begin
						stack_we               = exec_go;
						depth_n                = depth_q + 1'b1;
						res_n.returned_to_pool = 1'b1;
					end else begin
						res_n.status = ST_LIMIT;
					end
				end
				OP_ADDREF: begin
					if (ref_rd_q == COUNT_MAX) begin
						res_n.status = ST_LIMIT;
						cnt_n        = COUNT_MAX;
					end else begin
						cnt_n  = ref_rd_q + 1'b1;
						ref_we = exec_go;
						ref_wd = cnt_n;
					end
					cnt_x           = RW'(cnt_n);
					res_n.ref_value = cnt_x[REF_W-1:0];
				end
				OP_READ: begin
					cnt_x           = RW'(ref_rd_q);
					res_n.ref_value = cnt_x[REF_W-1:0];
				end
				default: begin
					// allocate is handled above
					res_n.status = ST_OK;
				end
			endcase
		end
	end

	// Count table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_wa] <= ref_wd;
		end
		if (accept) begin
			ref_rd_q <= ref_mem[ref_ra];
		end
	end

	// Free stack: push at depth, read the top at accept
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_wa] <= page_q;
		end
		if (accept) begin
			stack_rd_q <= stack_mem[depth_q[AW-1:0] - 1'b1];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= FIRST_PAGE_RESET;
			limit_q <= LIMIT_PAGE_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FIRST_PAGE: first_q <= cfg_data;
				REG_LIMIT_PAGE: limit_q <= cfg_data;
				default:        first_q <= first_q;
			endcase
		end
	end

	// Sequencer, request capture and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
			op_q        <= OP_ALLOC;
			page_q      <= '0;
			res_q       <= '0;
		end else begin
			// raise valid on an update, drop the result once taken
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= op_t'(s_tdata[1:0]);
						page_q  <= in_page;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// hold until the result register is free
					if (exec_go) begin
						depth_q <= depth_n;
						res_q   <= res_n;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(res_q);

endmodule

>>> design/rpa_checker.sv
// Port-level checker for the page allocator, bound to the top level.
module rpa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [rpa_pkg::IN_TDATA_W-1:0]  s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rpa_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import rpa_pkg::*;

	result_t res;
	assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// every request passes through the update step before the next is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken in back-to-back cycles");

	// a page goes back to the pool only with a zero count and ok status
	a_return_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.returned_to_pool |-> res.status == ST_OK && res.ref_value == '0)
		else $error("returned page with nonzero count or error");

	// rejected pages report no count
	a_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == ST_WINDOW |->
			res.ref_value == '0 && !res.returned_to_pool)
		else $error("rejected page carries a count");

	// empty pool hands out page zero with no count
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status == ST_EMPTY |->
			res.page_out == '0 && res.ref_value == '0 && !res.returned_to_pool)
		else $error("empty-pool result not cleared");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (.*);
